FILE: rtl/ddpu_pkg.sv
`timescale 1ns / 1ps

package ddpu_pkg;

    // cordic
    localparam int CORDIC_STEPS = 24;
    localparam int CORD_IW      = 5;   // index into the 32-entry atan table
    localparam logic signed [33:0] CORDIC_KINV = 34'sd163008219;  // 1/gain, Q28
    localparam logic signed [34:0] ONE_Q28     = 35'sd268435456;

    // atan(2^-i) in turns, Q0.32
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // pi/180 in Q0.32
    localparam logic signed [63:0] DEG_TO_RAD_Q32 = 64'sd74961321;

    // serial multiplier: 64x64 magnitudes, one 8-bit digit per cycle
    localparam int MUL_W     = 64;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = MUL_W / MUL_DIGIT;

    // restoring divider
    localparam int DIV_NW = 80;
    localparam int DIV_DW = 64;

    // integer square root, two radicand bits per step
    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = SQRT_W / 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        SP_V1, SP_V2, SP_SQA, SP_SQB, SP_SQRT,
        SP_NX, SP_NY, SP_D1, SP_D2, SP_TLX, SP_TLY, SP_TRX, SP_TRY,
        SP_P, SP_Q, SP_CORD, SP_E1, SP_E2, SP_E3, SP_E4,
        SP_RLXM, SP_RLXD, SP_RLYM, SP_RLYD, SP_RRXM, SP_RRXD, SP_RRYM, SP_RRYD
    } step_t;

    typedef struct packed {
        logic mul;
        logic div;
        logic sqrt;
        logic cord;
    } unit_sel_t;

    function automatic unit_sel_t unit_of(input step_t s);
        unit_sel_t r;
        r = '0;
        unique case (s) inside
            SP_NX, SP_NY, SP_Q, SP_RLXD, SP_RLYD, SP_RRXD, SP_RRYD: r.div = 1'b1;
            SP_SQRT: r.sqrt = 1'b1;
            SP_CORD: r.cord = 1'b1;
            default: r.mul = 1'b1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ddpu_mul.sv
`timescale 1ns / 1ps

// sign-magnitude multiplier, one digit of b per cycle, msb first
module ddpu_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [ddpu_pkg::MUL_W-1:0] a,
    input  logic signed [ddpu_pkg::MUL_W-1:0] b,
    output logic                              done,
    output logic [ddpu_pkg::PROD_W-1:0]       mag,
    output logic                              neg
);

    localparam int CW = $clog2(ddpu_pkg::MUL_STEPS);

    logic                                  busy_reg, done_reg;
    logic [CW-1:0]                         cnt_reg;
    logic [ddpu_pkg::MUL_W-1:0]            a_mag_reg, b_sh_reg;
    logic [ddpu_pkg::PROD_W-1:0]           acc_reg;
    logic                                  neg_reg;
    logic [ddpu_pkg::MUL_W-1:0]            a_mag, b_mag;
    logic [ddpu_pkg::MUL_W+ddpu_pkg::MUL_DIGIT-1:0] pp;

    assign a_mag = a[ddpu_pkg::MUL_W-1] ? (~a + 1'b1) : a;
    assign b_mag = b[ddpu_pkg::MUL_W-1] ? (~b + 1'b1) : b;
    assign pp    = a_mag_reg * b_sh_reg[ddpu_pkg::MUL_W-1 -: ddpu_pkg::MUL_DIGIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ddpu_pkg::MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_mag_reg <= a_mag;
            b_sh_reg  <= b_mag;
            acc_reg   <= '0;
            neg_reg   <= a[ddpu_pkg::MUL_W-1] ^ b[ddpu_pkg::MUL_W-1];
        end else if (busy_reg) begin
            acc_reg  <= {acc_reg[ddpu_pkg::PROD_W-ddpu_pkg::MUL_DIGIT-1:0],
                         {ddpu_pkg::MUL_DIGIT{1'b0}}} + ddpu_pkg::PROD_W'(pp);
            b_sh_reg <= {b_sh_reg[ddpu_pkg::MUL_W-ddpu_pkg::MUL_DIGIT-1:0],
                         {ddpu_pkg::MUL_DIGIT{1'b0}}};
        end
    end

    assign done = done_reg;
    assign mag  = acc_reg;
    assign neg  = neg_reg;

endmodule

FILE: rtl/ddpu_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, truncates toward zero
module ddpu_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ddpu_pkg::DIV_NW-1:0]  num_mag,
    input  logic                         num_neg,
    input  logic [ddpu_pkg::DIV_DW-1:0]  den_mag,
    input  logic                         den_neg,
    output logic                         done,
    output logic signed [63:0]           quot
);

    localparam int CW = $clog2(ddpu_pkg::DIV_NW);

    logic                          busy_reg, done_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [ddpu_pkg::DIV_DW-1:0]   rem_reg, den_reg;
    logic [ddpu_pkg::DIV_NW-1:0]   nq_reg;
    logic                          neg_reg;
    logic [ddpu_pkg::DIV_DW:0]     trial, diff;
    logic                          ge;

    assign trial = {rem_reg, nq_reg[ddpu_pkg::DIV_NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ddpu_pkg::DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            nq_reg  <= num_mag;
            den_reg <= den_mag;
            neg_reg <= num_neg ^ den_neg;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[ddpu_pkg::DIV_DW-1:0] : trial[ddpu_pkg::DIV_DW-1:0];
            nq_reg  <= {nq_reg[ddpu_pkg::DIV_NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(nq_reg[63:0]) : $signed(nq_reg[63:0]);

endmodule

FILE: rtl/ddpu_sqrt.sv
`timescale 1ns / 1ps

// floor(sqrt(n)), bit-pair method
module ddpu_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ddpu_pkg::SQRT_W-1:0] n,
    output logic                        done,
    output logic [ddpu_pkg::SQRT_W/2-1:0] root
);

    localparam int CW = $clog2(ddpu_pkg::SQRT_STEPS);
    localparam int SW = $clog2(ddpu_pkg::SQRT_W);

    logic                        busy_reg, done_reg;
    logic [CW-1:0]               cnt_reg;
    logic [ddpu_pkg::SQRT_W-1:0] rem_reg, r_reg;
    logic [ddpu_pkg::SQRT_W-1:0] bitv, trial;
    logic [SW-1:0]               sh;

    assign sh    = SW'(ddpu_pkg::SQRT_W - 2) - {cnt_reg, 1'b0};
    assign bitv  = {{(ddpu_pkg::SQRT_W-1){1'b0}}, 1'b1} << sh;
    assign trial = r_reg + bitv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ddpu_pkg::SQRT_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= n;
            r_reg   <= '0;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                r_reg   <= (r_reg >> 1) + bitv;
            end else begin
                r_reg   <= r_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[ddpu_pkg::SQRT_W/2-1:0];

endmodule

FILE: rtl/ddpu_cordic.sv
`timescale 1ns / 1ps

// rotation-mode cordic, angle in turns Q0.32, cos/sin in Q28
module ddpu_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        ang,
    output logic               done,
    output logic signed [33:0] cos_q,
    output logic signed [33:0] sin_q
);

    localparam int IW = ddpu_pkg::CORD_IW;

    logic                busy_reg, done_reg;
    logic [IW-1:0]       cnt_reg;
    logic signed [33:0]  x_reg, y_reg, z_reg;
    logic signed [33:0]  z0, dx, dy, at;

    assign z0 = 34'($signed(ang));
    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = $signed(34'(ddpu_pkg::ATAN_TURNS[cnt_reg]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == IW'(ddpu_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg <= '0;
            // fold past a quarter turn by half a turn
            if (z0 > 34'sd1073741824) begin
                z_reg <= z0 - 34'sd2147483648;
                x_reg <= -ddpu_pkg::CORDIC_KINV;
            end else if (z0 < -34'sd1073741824) begin
                z_reg <= z0 + 34'sd2147483648;
                x_reg <= -ddpu_pkg::CORDIC_KINV;
            end else begin
                z_reg <= z0;
                x_reg <= ddpu_pkg::CORDIC_KINV;
            end
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = x_reg;
    assign sin_q = y_reg;

endmodule

FILE: rtl/differential_drive_pose_update_top.sv
`timescale 1ns / 1ps

// channel  | handshake         | word
// ---------+-------------------+-------------------------------------------------
// s_       | s_valid / s_ready | start_run, left_speed, right_speed, duration
// m_       | m_valid / m_ready | mid_x, mid_y
// cfg_     | cfg_we            | cfg_wdata = half_track
//
// One word at a time. A small sequencer runs the word through four serial
// units: multiplier, divider, square root and cordic. A straight move or a
// turn takes longer than coincident wheels, and the divider dominates.
// Reset (aresetn low, synchronous) puts the wheels at (-1,0) and (1,0).
// s_ready is high only when idle; a finished result waits in the output
// register while the next word may already be taken.
module differential_drive_pose_update_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [14:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_start_run,
    input  logic signed [31:0] s_left_speed,
    input  logic signed [31:0] s_right_speed,
    input  logic [31:0]        s_duration,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_mid_x,
    output logic signed [31:0] m_mid_y
);

    localparam int PW = ddpu_pkg::PROD_W;

    ddpu_pkg::state_t    state_reg, state_next;
    ddpu_pkg::step_t     step_reg, step_next;
    ddpu_pkg::unit_sel_t unit_req, unit_done, unit_cur;

    // config and wheel state
    logic [14:0]        half_track_reg;
    logic signed [31:0] lx_reg, ly_reg, rx_reg, ry_reg;

    // per-word working registers
    logic signed [31:0] v1d_reg, v2d_reg;
    logic [31:0]        t_reg;
    logic signed [31:0] v1r_reg, v2r_reg;
    logic [63:0]        sq_reg;
    logic [32:0]        len_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic signed [47:0] d1_reg, d2_reg;
    logic signed [63:0] nlx_reg, nly_reg, nrx_reg, nry_reg;
    logic [63:0]        p_reg;
    logic [31:0]        th_reg;
    logic signed [33:0] c_reg, s_reg;
    logic signed [65:0] eacc_reg;
    logic signed [37:0] ex_reg, ey_reg;
    logic signed [63:0] tmp_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_mid_x_reg, m_mid_y_reg;

    // unit ports
    logic signed [63:0] mul_a, mul_b;
    logic [PW-1:0]      mul_mag;
    logic               mul_neg;
    logic [79:0]        div_num_mag;
    logic               div_num_neg;
    logic [63:0]        div_den_mag;
    logic               div_den_neg;
    logic signed [63:0] div_q;
    logic [31:0]        sqrt_root;
    logic signed [33:0] cord_c, cord_s;

    // derived values
    logic               accept, capture, fin_fire;
    logic signed [31:0] h_pos;
    logic signed [32:0] ux, uy, dv, w, nv1, nv2;
    logic [32:0]        ux_mag, uy_mag, w_mag, ax, ay;
    logic               halve;
    logic [31:0]        ha;
    logic [32:0]        len_now;
    logic [41:0]        len360;
    logic signed [34:0] cm;
    logic [63:0]        tmp_mag;
    logic signed [PW:0] prod_s, rnd32, rnd16;
    logic [63:0]        q30_mag;
    logic signed [64:0] q30_s;
    logic signed [65:0] e_diff, e_sum, e_rnd_d, e_rnd_s;
    logic signed [31:0] sat_lx, sat_ly, sat_rx, sat_ry;
    logic signed [32:0] sum_x, sum_y, adj_x, adj_y;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    assign accept   = (state_reg == ddpu_pkg::ST_IDLE) && s_valid;
    assign unit_cur = ddpu_pkg::unit_of(step_reg);
    assign capture  = (state_reg == ddpu_pkg::ST_WAIT) && ((unit_done & unit_cur) != '0);
    assign fin_fire = (state_reg == ddpu_pkg::ST_FINISH) && (!m_valid_reg || m_ready);

    assign h_pos = $signed({1'b0, half_track_reg, 16'b0});

    // axle vector and friends
    assign ux     = 33'(rx_reg) - 33'(lx_reg);
    assign uy     = 33'(ry_reg) - 33'(ly_reg);
    assign ux_mag = ux[32] ? 33'(-ux) : 33'(ux);
    assign uy_mag = uy[32] ? 33'(-uy) : 33'(uy);
    assign ax     = ux_mag;
    assign ay     = uy_mag;
    assign halve  = ax[32] | ax[31] | ay[32] | ay[31];
    assign ha     = halve ? ax[32:1] : ax[31:0];   // only one operand per step
    assign len_now = halve ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
    assign len360 = {len_reg, 9'b0} - 42'({len_reg, 7'b0}) - 42'({len_reg, 4'b0})
                    - 42'({len_reg, 3'b0});  // *360
    assign dv     = 33'(v2d_reg) - 33'(v1d_reg);
    assign w      = 33'(v1r_reg) - 33'(v2r_reg);
    assign w_mag  = w[32] ? 33'(-w) : 33'(w);
    assign nv1    = -33'(v1r_reg);
    assign nv2    = -33'(v2r_reg);
    assign cm     = 35'(c_reg) - ddpu_pkg::ONE_Q28;
    assign tmp_mag = tmp_reg[63] ? 64'(-tmp_reg) : 64'(tmp_reg);

    // multiplier result, signed, with the roundings used downstream
    assign prod_s = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
    assign rnd32  = prod_s + $signed((PW+1)'(64'h8000_0000));
    assign rnd16  = prod_s + $signed((PW+1)'(64'h8000));
    // floor(|a|*|b| / 2^30) with the product sign
    assign q30_mag = mul_mag[93:30];
    assign q30_s   = mul_neg ? -$signed({1'b0, q30_mag}) : $signed({1'b0, q30_mag});
    assign e_diff  = eacc_reg - $signed(prod_s[65:0]);
    assign e_sum   = eacc_reg + $signed(prod_s[65:0]);
    assign e_rnd_d = e_diff + 66'sd134217728;
    assign e_rnd_s = e_sum + 66'sd134217728;

    // operand select
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        div_num_mag = '0;
        div_num_neg = 1'b0;
        div_den_mag = 64'(len_reg);
        div_den_neg = 1'b0;
        unique case (step_reg)
            ddpu_pkg::SP_V1: begin
                mul_a = 64'(v1d_reg);
                mul_b = ddpu_pkg::DEG_TO_RAD_Q32;
            end
            ddpu_pkg::SP_V2: begin
                mul_a = 64'(v2d_reg);
                mul_b = ddpu_pkg::DEG_TO_RAD_Q32;
            end
            ddpu_pkg::SP_SQA: begin
                mul_a = $signed(64'(ha));
                mul_b = $signed(64'(ha));
            end
            ddpu_pkg::SP_SQB: begin
                mul_a = $signed(64'(halve ? ay[32:1] : ay[31:0]));
                mul_b = $signed(64'(halve ? ay[32:1] : ay[31:0]));
            end
            ddpu_pkg::SP_SQRT: begin
                mul_a = '0;
            end
            ddpu_pkg::SP_NX: begin
                // -uy * 2^30 / len
                div_num_mag = 80'({uy_mag, 30'b0});
                div_num_neg = (uy > 33'sd0);
            end
            ddpu_pkg::SP_NY: begin
                div_num_mag = 80'({ux_mag, 30'b0});
                div_num_neg = ux[32];
            end
            ddpu_pkg::SP_D1: begin
                mul_a = 64'(v1r_reg);
                mul_b = $signed(64'(t_reg));
            end
            ddpu_pkg::SP_D2: begin
                mul_a = 64'(v2r_reg);
                mul_b = $signed(64'(t_reg));
            end
            ddpu_pkg::SP_TLX: begin
                mul_a = 64'(nx_reg);
                mul_b = 64'(d1_reg);
            end
            ddpu_pkg::SP_TLY: begin
                mul_a = 64'(ny_reg);
                mul_b = 64'(d1_reg);
            end
            ddpu_pkg::SP_TRX: begin
                mul_a = 64'(nx_reg);
                mul_b = 64'(d2_reg);
            end
            ddpu_pkg::SP_TRY: begin
                mul_a = 64'(ny_reg);
                mul_b = 64'(d2_reg);
            end
            ddpu_pkg::SP_P: begin
                mul_a = 64'(dv);
                mul_b = $signed(64'(t_reg));
            end
            ddpu_pkg::SP_Q: begin
                // turn fraction, Q0.32 modulo one turn
                div_num_mag = {p_reg, 16'b0};
                div_den_mag = 64'(len360);
            end
            ddpu_pkg::SP_CORD: begin
                mul_a = '0;
            end
            ddpu_pkg::SP_E1: begin
                mul_a = 64'(cm);
                mul_b = 64'(ux);
            end
            ddpu_pkg::SP_E2: begin
                mul_a = 64'(s_reg);
                mul_b = 64'(uy);
            end
            ddpu_pkg::SP_E3: begin
                mul_a = 64'(s_reg);
                mul_b = 64'(ux);
            end
            ddpu_pkg::SP_E4: begin
                mul_a = 64'(cm);
                mul_b = 64'(uy);
            end
            ddpu_pkg::SP_RLXM: begin
                mul_a = 64'(ex_reg);
                mul_b = 64'(nv1);
            end
            ddpu_pkg::SP_RLYM: begin
                mul_a = 64'(ey_reg);
                mul_b = 64'(nv1);
            end
            ddpu_pkg::SP_RRXM: begin
                mul_a = 64'(ex_reg);
                mul_b = 64'(nv2);
            end
            ddpu_pkg::SP_RRYM: begin
                mul_a = 64'(ey_reg);
                mul_b = 64'(nv2);
            end
            ddpu_pkg::SP_RLXD, ddpu_pkg::SP_RLYD,
            ddpu_pkg::SP_RRXD, ddpu_pkg::SP_RRYD: begin
                div_num_mag = 80'(tmp_mag);
                div_num_neg = tmp_reg[63];
                div_den_mag = 64'(w_mag);
                div_den_neg = w[32];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unit_req   = '0;
        unique case (state_reg)
            ddpu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ddpu_pkg::ST_ISSUE;
                    step_next  = ddpu_pkg::SP_V1;
                end
            end
            ddpu_pkg::ST_ISSUE: begin
                unit_req   = unit_cur;
                state_next = ddpu_pkg::ST_WAIT;
            end
            ddpu_pkg::ST_WAIT: begin
                if (capture) begin
                    state_next = ddpu_pkg::ST_ISSUE;
                    unique case (step_reg)
                        ddpu_pkg::SP_V1:   step_next = ddpu_pkg::SP_V2;
                        ddpu_pkg::SP_V2:   step_next = ddpu_pkg::SP_SQA;
                        ddpu_pkg::SP_SQA:  step_next = ddpu_pkg::SP_SQB;
                        ddpu_pkg::SP_SQB:  step_next = ddpu_pkg::SP_SQRT;
                        ddpu_pkg::SP_SQRT: begin
                            // coincident wheels: nothing moves
                            if (sqrt_root == '0) begin
                                state_next = ddpu_pkg::ST_FINISH;
                            end else if (v1r_reg == v2r_reg) begin
                                step_next = ddpu_pkg::SP_NX;
                            end else begin
                                step_next = ddpu_pkg::SP_P;
                            end
                        end
                        ddpu_pkg::SP_NX:   step_next = ddpu_pkg::SP_NY;
                        ddpu_pkg::SP_NY:   step_next = ddpu_pkg::SP_D1;
                        ddpu_pkg::SP_D1:   step_next = ddpu_pkg::SP_D2;
                        ddpu_pkg::SP_D2:   step_next = ddpu_pkg::SP_TLX;
                        ddpu_pkg::SP_TLX:  step_next = ddpu_pkg::SP_TLY;
                        ddpu_pkg::SP_TLY:  step_next = ddpu_pkg::SP_TRX;
                        ddpu_pkg::SP_TRX:  step_next = ddpu_pkg::SP_TRY;
                        ddpu_pkg::SP_P:    step_next = ddpu_pkg::SP_Q;
                        ddpu_pkg::SP_Q:    step_next = ddpu_pkg::SP_CORD;
                        ddpu_pkg::SP_CORD: step_next = ddpu_pkg::SP_E1;
                        ddpu_pkg::SP_E1:   step_next = ddpu_pkg::SP_E2;
                        ddpu_pkg::SP_E2:   step_next = ddpu_pkg::SP_E3;
                        ddpu_pkg::SP_E3:   step_next = ddpu_pkg::SP_E4;
                        ddpu_pkg::SP_E4:   step_next = ddpu_pkg::SP_RLXM;
                        ddpu_pkg::SP_RLXM: step_next = ddpu_pkg::SP_RLXD;
                        ddpu_pkg::SP_RLXD: step_next = ddpu_pkg::SP_RLYM;
                        ddpu_pkg::SP_RLYM: step_next = ddpu_pkg::SP_RLYD;
                        ddpu_pkg::SP_RLYD: step_next = ddpu_pkg::SP_RRXM;
                        ddpu_pkg::SP_RRXM: step_next = ddpu_pkg::SP_RRXD;
                        ddpu_pkg::SP_RRXD: step_next = ddpu_pkg::SP_RRYM;
                        ddpu_pkg::SP_RRYM: step_next = ddpu_pkg::SP_RRYD;
                        default:           state_next = ddpu_pkg::ST_FINISH;
                    endcase
                end
            end
            ddpu_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ddpu_pkg::ST_IDLE;
                end
            end
            default: state_next = ddpu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddpu_pkg::ST_IDLE;
            step_reg  <= ddpu_pkg::SP_V1;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // saturated wheel positions and midpoint (truncated toward zero)
    assign sat_lx = sat32(nlx_reg);
    assign sat_ly = sat32(nly_reg);
    assign sat_rx = sat32(nrx_reg);
    assign sat_ry = sat32(nry_reg);
    assign sum_x  = 33'(sat_lx) + 33'(sat_rx);
    assign sum_y  = 33'(sat_ly) + 33'(sat_ry);
    assign adj_x  = sum_x + 33'(sum_x[32]);
    assign adj_y  = sum_y + 33'(sum_y[32]);

    // control state: config, wheels, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_track_reg <= 15'd1;
            lx_reg         <= -32'sd65536;
            ly_reg         <= '0;
            rx_reg         <= 32'sd65536;
            ry_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                half_track_reg <= cfg_wdata;
            end
            if (accept && s_start_run) begin
                lx_reg <= -h_pos;
                ly_reg <= '0;
                rx_reg <= h_pos;
                ry_reg <= '0;
            end else if (fin_fire) begin
                lx_reg <= sat_lx;
                ly_reg <= sat_ly;
                rx_reg <= sat_rx;
                ry_reg <= sat_ry;
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            v1d_reg <= s_left_speed;
            v2d_reg <= s_right_speed;
            t_reg   <= s_duration;
            nlx_reg <= s_start_run ? 64'(-h_pos) : 64'(lx_reg);
            nly_reg <= s_start_run ? 64'sd0 : 64'(ly_reg);
            nrx_reg <= s_start_run ? 64'(h_pos) : 64'(rx_reg);
            nry_reg <= s_start_run ? 64'sd0 : 64'(ry_reg);
        end
        if (fin_fire) begin
            m_mid_x_reg <= adj_x[32:1];
            m_mid_y_reg <= adj_y[32:1];
        end
        if (capture) begin
            case (step_reg)
                ddpu_pkg::SP_V1:   v1r_reg <= rnd32[63:32];
                ddpu_pkg::SP_V2:   v2r_reg <= rnd32[63:32];
                ddpu_pkg::SP_SQA:  sq_reg  <= mul_mag[63:0];
                ddpu_pkg::SP_SQB:  sq_reg  <= sq_reg + mul_mag[63:0];
                ddpu_pkg::SP_SQRT: len_reg <= len_now;
                ddpu_pkg::SP_NX:   nx_reg  <= div_q[31:0];
                ddpu_pkg::SP_NY:   ny_reg  <= div_q[31:0];
                ddpu_pkg::SP_D1:   d1_reg  <= rnd16[63:16];
                ddpu_pkg::SP_D2:   d2_reg  <= rnd16[63:16];
                ddpu_pkg::SP_TLX:  nlx_reg <= nlx_reg + q30_s[63:0];
                ddpu_pkg::SP_TLY:  nly_reg <= nly_reg + q30_s[63:0];
                ddpu_pkg::SP_TRX:  nrx_reg <= nrx_reg + q30_s[63:0];
                ddpu_pkg::SP_TRY:  nry_reg <= nry_reg + q30_s[63:0];
                ddpu_pkg::SP_P:    p_reg   <= mul_mag[63:0];
                ddpu_pkg::SP_Q:    th_reg  <= dv[32] ? -div_q[31:0] : div_q[31:0];
                ddpu_pkg::SP_CORD: begin
                    c_reg <= cord_c;
                    s_reg <= cord_s;
                end
                ddpu_pkg::SP_E1:   eacc_reg <= prod_s[65:0];
                ddpu_pkg::SP_E2:   ex_reg   <= e_rnd_d[65:28];
                ddpu_pkg::SP_E3:   eacc_reg <= prod_s[65:0];
                ddpu_pkg::SP_E4:   ey_reg   <= e_rnd_s[65:28];
                ddpu_pkg::SP_RLXM, ddpu_pkg::SP_RLYM,
                ddpu_pkg::SP_RRXM, ddpu_pkg::SP_RRYM: tmp_reg <= prod_s[63:0];
                ddpu_pkg::SP_RLXD: nlx_reg <= nlx_reg + div_q;
                ddpu_pkg::SP_RLYD: nly_reg <= nly_reg + div_q;
                ddpu_pkg::SP_RRXD: nrx_reg <= nrx_reg + div_q;
                ddpu_pkg::SP_RRYD: nry_reg <= nry_reg + div_q;
                default: begin
                end
            endcase
        end
    end

    ddpu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_req.mul),
        .a       (mul_a),
        .b       (mul_b),
        .done    (unit_done.mul),
        .mag     (mul_mag),
        .neg     (mul_neg)
    );

    ddpu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_req.div),
        .num_mag (div_num_mag),
        .num_neg (div_num_neg),
        .den_mag (div_den_mag),
        .den_neg (div_den_neg),
        .done    (unit_done.div),
        .quot    (div_q)
    );

    ddpu_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_req.sqrt),
        .n       (sq_reg),
        .done    (unit_done.sqrt),
        .root    (sqrt_root)
    );

    ddpu_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_req.cord),
        .ang     (th_reg),
        .done    (unit_done.cord),
        .cos_q   (cord_c),
        .sin_q   (cord_s)
    );

    assign s_ready = (state_reg == ddpu_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_mid_x = m_mid_x_reg;
    assign m_mid_y = m_mid_y_reg;

    // checks
    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(unit_req))
        else $error("more than one unit started");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ddpu_pkg::ST_ISSUE)
                                 && (step_reg == ddpu_pkg::SP_V1))
        else $error("accepted word did not start the sequence");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ddpu_pkg::ST_FINISH))
        else $error("result raised outside finish");

    a_no_stray_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddpu_pkg::ST_WAIT) |-> ((unit_done & ~unit_cur) == '0))
        else $error("done from a unit that was not started");

endmodule
